// ----- rtl/rkf_pkg.sv -----
// rkf_pkg: shared constants, types and state encodings for the rgba keyframe fader
// used by rkf_queue, rkf_blend and rgba_keyframe_fader_core; depends on nothing
`default_nettype none

package rkf_pkg;

  localparam int QUEUE_DEPTH = 16;
  localparam int TIME_BITS   = 16;
  localparam int IDX_W       = $clog2(QUEUE_DEPTH);
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

  localparam int CHANNELS  = 4;
  localparam int CH_W      = 8;
  localparam int CHIDX_W   = $clog2(CHANNELS);
  localparam int COLOR_W   = CHANNELS * CH_W;
  localparam int QBIT_W    = $clog2(CH_W);
  localparam int PROD_W    = TIME_BITS + CH_W;

  localparam logic [COLOR_W-1:0] COLOR_FULL = '1;

  // input word layout
  localparam int IN_COLOR_LSB   = 0;
  localparam int IN_DUR_LSB     = COLOR_W;
  localparam int IN_ELAPSED_LSB = COLOR_W + TIME_BITS;
  localparam int IN_DATA_W      = COLOR_W + 2 * TIME_BITS;
  localparam int MODE_W         = 3;

  // output word layout
  localparam int OUT_BUSY_BIT  = COLOR_W;
  localparam int OUT_LEVEL_LSB = COLOR_W + 1;
  localparam int OUT_DROP_BIT  = COLOR_W + 1 + CNT_W;
  localparam int OUT_USED_W    = COLOR_W + 2 + CNT_W;
  localparam int OUT_DATA_W    = ((OUT_USED_W + 7) / 8) * 8;

  typedef enum logic [MODE_W-1:0] {
    MODE_PUSH      = 3'd0,
    MODE_START     = 3'd1,
    MODE_STOP      = 3'd2,
    MODE_TICK      = 3'd3,
    MODE_SET_COLOR = 3'd4
  } mode_t;

  typedef struct packed {
    logic [TIME_BITS-1:0] duration;
    logic [COLOR_W-1:0]   color;
  } frame_t;

  typedef struct packed {
    logic   push;
    logic   pop;
    frame_t frame;
  } queue_cmd_t;

  typedef struct packed {
    logic                 go;
    logic [COLOR_W-1:0]   from_color;
    logic [COLOR_W-1:0]   to_color;
    logic [TIME_BITS-1:0] t;
    logic [TIME_BITS-1:0] d;
  } blend_req_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_BLEND,
    ST_POP,
    ST_LOAD,
    ST_DONE
  } fsm_state_t;

  typedef enum logic [1:0] {
    B_IDLE,
    B_MUL,
    B_DIV,
    B_DONE
  } blend_state_t;

endpackage

`default_nettype wire

// ----- rtl/rkf_queue.sv -----
// rkf_queue: keyframe fifo, one synchronous memory plus head, tail and fill count
// uses rkf_pkg; read data is the head entry, registered, so it follows head in the cycle after
`default_nettype none

module rkf_queue (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire rkf_pkg::queue_cmd_t      cmd,
  output rkf_pkg::frame_t               head_frame,
  output logic [rkf_pkg::CNT_W-1:0]     level
);

  rkf_pkg::frame_t mem [rkf_pkg::QUEUE_DEPTH];

  logic [rkf_pkg::IDX_W-1:0] head;
  logic [rkf_pkg::IDX_W-1:0] tail;
  logic [rkf_pkg::CNT_W-1:0] count;
  logic [rkf_pkg::IDX_W-1:0] head_next;
  logic [rkf_pkg::IDX_W-1:0] tail_next;

  assign head_next = (head == rkf_pkg::IDX_W'(rkf_pkg::QUEUE_DEPTH - 1)) ? '0 : head + 1'b1;
  assign tail_next = (tail == rkf_pkg::IDX_W'(rkf_pkg::QUEUE_DEPTH - 1)) ? '0 : tail + 1'b1;
  assign level     = count;

  // read during write returns old data; the controller never needs the new one that soon
  always_ff @(posedge clk) begin
    if (cmd.push) begin
      mem[tail] <= cmd.frame;
    end
    head_frame <= mem[head];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      tail  <= '0;
      count <= '0;
    end else begin
      if (cmd.push) begin
        tail  <= tail_next;
        count <= count + 1'b1;
      end
      if (cmd.pop) begin
        head  <= head_next;
        count <= count - 1'b1;
      end
    end
  end

  a_no_push_pop: assert property (@(posedge clk) disable iff (rst)
    !(cmd.push && cmd.pop))
    else $error("queue push and pop in the same cycle");

  a_push_not_full: assert property (@(posedge clk) disable iff (rst)
    cmd.push |-> count < rkf_pkg::CNT_W'(rkf_pkg::QUEUE_DEPTH))
    else $error("push into full queue");

  a_pop_not_empty: assert property (@(posedge clk) disable iff (rst)
    cmd.pop |-> count != '0)
    else $error("pop from empty queue");

endmodule

`default_nettype wire

// ----- rtl/rkf_blend.sv -----
// rkf_blend: shared interpolation unit, channels one after another
// per channel one multiply then eight restoring divide steps, divide skipped at zero duration; uses rkf_pkg
`default_nettype none

module rkf_blend (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire rkf_pkg::blend_req_t        req,
  output logic                            done,
  output logic [rkf_pkg::COLOR_W-1:0]     color
);

  rkf_pkg::blend_state_t state;
  rkf_pkg::blend_state_t state_next;

  logic [rkf_pkg::COLOR_W-1:0]   from_color;
  logic [rkf_pkg::COLOR_W-1:0]   to_color;
  logic [rkf_pkg::TIME_BITS-1:0] t;
  logic [rkf_pkg::TIME_BITS-1:0] d;
  logic [rkf_pkg::CHIDX_W-1:0]   ch;
  logic [rkf_pkg::QBIT_W-1:0]    bitpos;
  logic                          neg;
  logic [rkf_pkg::PROD_W-1:0]    rem;
  logic [rkf_pkg::CH_W-1:0]      quot;

  logic [rkf_pkg::CH_W-1:0]   s_ch;
  logic [rkf_pkg::CH_W-1:0]   e_ch;
  logic [rkf_pkg::CH_W-1:0]   mag;
  logic [rkf_pkg::PROD_W-1:0] dsh;
  logic                       ge;
  logic [rkf_pkg::CH_W-1:0]   quot_next;
  logic [rkf_pkg::CH_W-1:0]   ch_value;
  logic                       last_ch;
  logic                       ch_finish;

  assign s_ch      = from_color[ch*rkf_pkg::CH_W +: rkf_pkg::CH_W];
  assign e_ch      = to_color[ch*rkf_pkg::CH_W +: rkf_pkg::CH_W];
  assign mag       = (e_ch < s_ch) ? s_ch - e_ch : e_ch - s_ch;
  assign dsh       = rkf_pkg::PROD_W'(d) << bitpos;
  assign ge        = rem >= dsh;
  assign quot_next = {quot[rkf_pkg::CH_W-2:0], ge};
  // quotient never exceeds the channel distance since t <= d, so no clamp is needed
  assign ch_value  = neg ? s_ch - quot_next : s_ch + quot_next;
  assign last_ch   = ch == rkf_pkg::CHIDX_W'(rkf_pkg::CHANNELS - 1);
  assign ch_finish = ((state == rkf_pkg::B_MUL) && (d == '0)) ||
                     ((state == rkf_pkg::B_DIV) && (bitpos == '0));
  assign done      = state == rkf_pkg::B_DONE;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= rkf_pkg::B_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      rkf_pkg::B_IDLE: begin
        if (req.go) begin
          state_next = rkf_pkg::B_MUL;
        end
      end
      rkf_pkg::B_MUL: begin
        if (d == '0) begin
          state_next = last_ch ? rkf_pkg::B_DONE : rkf_pkg::B_MUL;
        end else begin
          state_next = rkf_pkg::B_DIV;
        end
      end
      rkf_pkg::B_DIV: begin
        if (bitpos == '0) begin
          state_next = last_ch ? rkf_pkg::B_DONE : rkf_pkg::B_MUL;
        end
      end
      rkf_pkg::B_DONE: begin
        state_next = rkf_pkg::B_IDLE;
      end
      default: begin
        state_next = rkf_pkg::B_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (state == rkf_pkg::B_IDLE && req.go) begin
      from_color <= req.from_color;
      to_color   <= req.to_color;
      t          <= req.t;
      d          <= req.d;
      ch         <= '0;
    end
    if (state == rkf_pkg::B_MUL) begin
      neg    <= e_ch < s_ch;
      rem    <= rkf_pkg::PROD_W'(mag) * rkf_pkg::PROD_W'(t);
      quot   <= '0;
      bitpos <= rkf_pkg::QBIT_W'(rkf_pkg::CH_W - 1);
      // zero duration jumps to the end value
      if (d == '0) begin
        color[ch*rkf_pkg::CH_W +: rkf_pkg::CH_W] <= e_ch;
      end
    end
    if (state == rkf_pkg::B_DIV) begin
      quot   <= quot_next;
      bitpos <= bitpos - 1'b1;
      if (ge) begin
        rem <= rem - dsh;
      end
      if (bitpos == '0) begin
        color[ch*rkf_pkg::CH_W +: rkf_pkg::CH_W] <= ch_value;
      end
    end
    if (ch_finish && !last_ch) begin
      ch <= ch + 1'b1;
    end
  end

  a_go_when_idle: assert property (@(posedge clk) disable iff (rst)
    req.go |-> state == rkf_pkg::B_IDLE)
    else $error("blend started while busy");

  a_done_pulse: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("blend done longer than one cycle");

endmodule

`default_nettype wire

// ----- rtl/rgba_keyframe_fader_core.sv -----
// One result word per input word. Push, start, stop and set-color words, and ticks while
// stopped, go from accept through the exec and done states to the output register. A tick
// on a running fade also passes through the shared blend unit, which does one multiply
// and eight restoring divide steps per channel over four channels, one after another.
// When the keyframe ends and the next one is loaded from the keyframe memory, the tick
// passes through the pop and load states as well. A zero-length keyframe skips the divide.
// A stalled output holds the word in the done state. The next word is accepted once the
// current one is finished, even if its result is still waiting in the output register.
// Top level of the rgba keyframe fader: controller, output register and glue
// depends on rkf_pkg, rkf_queue and rkf_blend
`default_nettype none

module rgba_keyframe_fader_core (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            s_tvalid,
  output logic                                 s_tready,
  // red_in, green_in, blue_in, alpha_in, duration_ticks, elapsed_ticks
  input  wire logic [rkf_pkg::IN_DATA_W-1:0]   s_tdata,
  // mode
  input  wire logic [rkf_pkg::MODE_W-1:0]      s_tuser,
  output logic                                 m_tvalid,
  input  wire logic                            m_tready,
  // red_out, green_out, blue_out, alpha_out, busy_res, queue_level, push_dropped, pad
  output logic [rkf_pkg::OUT_DATA_W-1:0]       m_tdata
);

  rkf_pkg::fsm_state_t state;
  rkf_pkg::fsm_state_t state_next;

  rkf_pkg::mode_t                mode;
  logic [rkf_pkg::COLOR_W-1:0]   in_color;
  logic [rkf_pkg::TIME_BITS-1:0] in_duration;
  logic [rkf_pkg::TIME_BITS-1:0] in_elapsed;

  logic [rkf_pkg::COLOR_W-1:0]   start_color;
  logic [rkf_pkg::COLOR_W-1:0]   end_color;
  logic [rkf_pkg::COLOR_W-1:0]   current_color;
  logic [rkf_pkg::TIME_BITS-1:0] time_in_frame;
  logic                          running;
  logic                          dropped;

  rkf_pkg::queue_cmd_t           qcmd;
  rkf_pkg::frame_t               head_frame;
  logic [rkf_pkg::CNT_W-1:0]     level;
  rkf_pkg::blend_req_t           breq;
  logic                          blend_done;
  logic [rkf_pkg::COLOR_W-1:0]   blend_color;

  logic                          accept;
  logic                          out_load;
  logic                          queue_full;
  logic [rkf_pkg::TIME_BITS:0]   time_sum;
  logic [rkf_pkg::TIME_BITS-1:0] time_new;
  logic                          frame_end;

  assign accept     = s_tvalid && s_tready;
  assign s_tready   = state == rkf_pkg::ST_IDLE;
  assign out_load   = (state == rkf_pkg::ST_DONE) && (!m_tvalid || m_tready);
  assign queue_full = level == rkf_pkg::CNT_W'(rkf_pkg::QUEUE_DEPTH);
  assign time_sum   = {1'b0, time_in_frame} + {1'b0, in_elapsed};
  assign time_new   = (time_sum >= {1'b0, head_frame.duration}) ?
                      head_frame.duration : time_sum[rkf_pkg::TIME_BITS-1:0];
  assign frame_end  = time_in_frame == head_frame.duration;

  rkf_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .cmd        (qcmd),
    .head_frame (head_frame),
    .level      (level)
  );

  rkf_blend u_blend (
    .clk   (clk),
    .rst   (rst),
    .req   (breq),
    .done  (blend_done),
    .color (blend_color)
  );

  always_comb begin
    qcmd.push           = (state == rkf_pkg::ST_EXEC) && (mode == rkf_pkg::MODE_PUSH) &&
                          !queue_full;
    qcmd.pop            = (state == rkf_pkg::ST_BLEND) && blend_done && frame_end;
    qcmd.frame.color    = in_color;
    qcmd.frame.duration = in_duration;
    breq.go             = (state == rkf_pkg::ST_EXEC) && (mode == rkf_pkg::MODE_TICK) &&
                          running;
    breq.from_color     = start_color;
    breq.to_color       = end_color;
    breq.t              = time_new;
    breq.d              = head_frame.duration;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= rkf_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      rkf_pkg::ST_IDLE: begin
        if (accept) begin
          state_next = rkf_pkg::ST_EXEC;
        end
      end
      rkf_pkg::ST_EXEC: begin
        state_next = breq.go ? rkf_pkg::ST_BLEND : rkf_pkg::ST_DONE;
      end
      rkf_pkg::ST_BLEND: begin
        if (blend_done) begin
          // the popped entry was the last one: nothing to load
          if (frame_end && level != rkf_pkg::CNT_W'(1)) begin
            state_next = rkf_pkg::ST_POP;
          end else begin
            state_next = rkf_pkg::ST_DONE;
          end
        end
      end
      rkf_pkg::ST_POP: begin
        state_next = rkf_pkg::ST_LOAD;
      end
      rkf_pkg::ST_LOAD: begin
        state_next = rkf_pkg::ST_DONE;
      end
      rkf_pkg::ST_DONE: begin
        if (out_load) begin
          state_next = rkf_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = rkf_pkg::ST_IDLE;
      end
    endcase
  end

  // input word capture
  always_ff @(posedge clk) begin
    if (accept) begin
      mode        <= rkf_pkg::mode_t'(s_tuser);
      in_color    <= s_tdata[rkf_pkg::IN_COLOR_LSB +: rkf_pkg::COLOR_W];
      in_duration <= s_tdata[rkf_pkg::IN_DUR_LSB +: rkf_pkg::TIME_BITS];
      in_elapsed  <= s_tdata[rkf_pkg::IN_ELAPSED_LSB +: rkf_pkg::TIME_BITS];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      start_color   <= rkf_pkg::COLOR_FULL;
      end_color     <= rkf_pkg::COLOR_FULL;
      current_color <= rkf_pkg::COLOR_FULL;
      time_in_frame <= '0;
      running       <= 1'b0;
      dropped       <= 1'b0;
    end else begin
      if (state == rkf_pkg::ST_EXEC) begin
        dropped <= 1'b0;
        case (mode)
          rkf_pkg::MODE_PUSH: begin
            dropped <= queue_full;
          end
          rkf_pkg::MODE_START: begin
            if (!running && level != '0) begin
              running       <= 1'b1;
              start_color   <= current_color;
              end_color     <= head_frame.color;
              time_in_frame <= '0;
            end
          end
          rkf_pkg::MODE_STOP: begin
            running <= 1'b0;
          end
          rkf_pkg::MODE_TICK: begin
            if (running) begin
              time_in_frame <= time_new;
            end
          end
          rkf_pkg::MODE_SET_COLOR: begin
            current_color <= in_color;
          end
          default: begin
          end
        endcase
      end
      if (state == rkf_pkg::ST_BLEND && blend_done) begin
        current_color <= blend_color;
        if (frame_end && level == rkf_pkg::CNT_W'(1)) begin
          running <= 1'b0;
        end
      end
      // next keyframe fades from the color just reached
      if (state == rkf_pkg::ST_LOAD) begin
        start_color   <= current_color;
        end_color     <= head_frame.color;
        time_in_frame <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_tdata <= rkf_pkg::OUT_DATA_W'({dropped, level, running, current_color});
    end
  end

  a_running_has_frame: assert property (@(posedge clk) disable iff (rst)
    (state == rkf_pkg::ST_IDLE && running) |-> level != '0)
    else $error("running with an empty queue");

  a_time_capped: assert property (@(posedge clk) disable iff (rst)
    (state == rkf_pkg::ST_IDLE && running) |-> time_in_frame <= head_frame.duration)
    else $error("time in frame beyond keyframe duration");

  a_blend_done_in_blend: assert property (@(posedge clk) disable iff (rst)
    blend_done |-> state == rkf_pkg::ST_BLEND)
    else $error("blend result arrived outside blend state");

endmodule

`default_nettype wire
